// ===== src/cht_pkg.sv =====
`default_nettype none
package cht_pkg;

  localparam int MAX_CODE_LEN_DEF = 15;
  localparam int MAX_SYMBOLS_DEF  = 512;
  localparam int SYM_W            = 10;
  localparam int CODE_W           = 16;

  typedef enum logic [2:0] {
    FN_CLEAR  = 3'd0,
    FN_LOAD   = 3'd1,
    FN_FIXLIT = 3'd2,
    FN_FIXDST = 3'd3,
    FN_LOOKUP = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  code_length;
    logic        last_length;
    logic [14:0] lookup_code;
    logic [3:0]  lookup_length;
  } in_beat_t;

  typedef struct packed {
    logic signed [9:0] symbol;
    logic              overflow;
  } out_beat_t;

  // map write request from the sequencer to the map memory
  typedef struct packed {
    logic              we;
    logic [CODE_W-1:0] addr;
    logic [SYM_W-1:0]  data;
  } map_wr_t;

  // fixed table runs: start key, first symbol, last symbol
  localparam int NUM_RUNS = 5;
  localparam logic [15:0] RUN_KEY   [NUM_RUNS] = '{16'h0130, 16'h0390, 16'h0080,
                                                   16'h01C0, 16'h0020};
  localparam logic [9:0]  RUN_FIRST [NUM_RUNS] = '{10'd0, 10'd144, 10'd256, 10'd280, 10'd0};
  localparam logic [9:0]  RUN_LAST  [NUM_RUNS] = '{10'd143, 10'd255, 10'd279, 10'd287,
                                                   10'd31};

endpackage
`default_nettype wire

// ===== src/cht_map.sv =====
`default_nettype none
module cht_map #(
  parameter int MAX_CODE_LEN = cht_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire cht_pkg::map_wr_t                  wr,
  input  wire logic [MAX_CODE_LEN:0]             rd_addr,
  output logic      [cht_pkg::SYM_W-1:0]         rd_data
);
  localparam int DEPTH = 1 << (MAX_CODE_LEN + 1);

  logic [cht_pkg::SYM_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[MAX_CODE_LEN:0]] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== src/canonical_huffman_table_top.sv =====
// canonical huffman decode table
// input channel: in_beat accepted when start is high and busy is low
// result channel: out_valid pulses for one cycle with out_beat; no backpressure
// every function ends in the done state; the result beat shows in the cycle
//   after it with busy already low, so the next beat can be taken with it
// length load (not last): stores the length and goes to done; no new beat is taken while busy
// lookup: busy through the address, memory read and done states
// clear: writes all 2^(MAX_CODE_LEN+1) map entries, one map entry per cycle, then done
// fixed literal/length load: 288 map entries, fixed distance load: 32 entries,
//   each then done
// build (last length): histogram pass over the N stored lengths, next codes for lengths
//   1 to 15, then a write pass over the N lengths, then done, N = symbols stored
// clear, histogram and write passes share one sequencer counter; fixed loads step key and symbol
// after reset the map is swept to "none" (all 2^(MAX_CODE_LEN+1) entries,
//   65536 by default) with busy high and no result beat
// results cannot be stalled; busy stays high until the result is shown
`default_nettype none
module canonical_huffman_table_top #(
  parameter int MAX_CODE_LEN = cht_pkg::MAX_CODE_LEN_DEF,
  parameter int MAX_SYMBOLS  = cht_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cht_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  output cht_pkg::out_beat_t      out_beat
);
  localparam int KW  = MAX_CODE_LEN + 1;
  localparam int SW  = $clog2(MAX_SYMBOLS);
  localparam int CW  = SW + 1;
  localparam logic [KW:0] MAP_DEPTH = {1'b1, {KW{1'b0}}};
  localparam logic [9:0]  NONE = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FIX, S_HIST, S_HIST_W, S_NEXT, S_WRITE, S_WRITE_W,
    S_LOOK, S_LOOK_W, S_DONE
  } state_t;

  state_t state_r;
  logic [KW:0]       cnt_r;
  logic [2:0]        run_r;
  logic [15:0]       key_r;
  logic [9:0]        sym_r;
  logic [CW-1:0]     count_r;
  logic              ovf_r;
  logic [9:0]        hist_r [16];
  logic [15:0]       next_r [16];
  logic [15:0]       code_r;
  logic [3:0]        len_r;
  logic              look_r;
  logic              sweep_r;
  logic [3:0]        lstore [MAX_SYMBOLS];
  logic [3:0]        lrd_r;
  logic [SW-1:0]     lwa;
  logic              lwe;
  logic [3:0]        lwd;
  logic [SW-1:0]     lra;
  cht_pkg::map_wr_t  mwr;
  logic [KW-1:0]     mra;
  logic [9:0]        mrd;

  cht_map #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_map (
    .clk(clk), .wr(mwr), .rd_addr(mra), .rd_data(mrd)
  );

  // length store, one write and one registered read
  always_ff @(posedge clk) begin
    if (lwe) begin
      lstore[lwa] <= lwd;
    end
    lrd_r <= lstore[lra];
  end

  assign lwe = (state_r == S_IDLE) && start && (in_beat.func == cht_pkg::FN_LOAD)
               && (count_r < CW'(MAX_SYMBOLS));
  assign lwa = count_r[SW-1:0];
  assign lwd = in_beat.code_length;
  assign lra = cnt_r[SW-1:0];
  assign mra = key_r[KW-1:0];
  assign busy = (state_r != S_IDLE);

  logic len_ok;
  assign len_ok = (lrd_r != 4'd0) && (32'(lrd_r) <= MAX_CODE_LEN);

  // map write mux
  always_comb begin
    mwr = '0;
    mwr.addr = 16'(cnt_r[KW-1:0]);
    mwr.data = NONE;
    if (state_r == S_CLEAR) begin
      mwr.we = 1'b1;
    end else if (state_r == S_FIX) begin
      mwr.we = 1'b1;
      mwr.addr = key_r;
      mwr.data = sym_r;
    end else if (state_r == S_WRITE_W && len_ok) begin
      mwr.we = 1'b1;
      mwr.addr = next_r[lrd_r] | (16'd1 << lrd_r);
      mwr.data = 10'(cnt_r - 1'b1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= 1'b1;
      cnt_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      look_r  <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        hist_r[i] <= '0;
        next_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cnt_r  <= '0;
          ovf_r  <= 1'b0;
          look_r <= 1'b0;
          if (start) begin
            unique case (in_beat.func) inside
              cht_pkg::FN_CLEAR: state_r <= S_CLEAR;
              cht_pkg::FN_LOAD: begin
                if (count_r < CW'(MAX_SYMBOLS)) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
                if (in_beat.last_length) begin
                  for (int i = 0; i < 16; i++) hist_r[i] <= '0;
                  state_r <= S_HIST;
                end else begin
                  state_r <= S_DONE;
                end
              end
              cht_pkg::FN_FIXLIT, cht_pkg::FN_FIXDST: begin
                run_r <= (in_beat.func == cht_pkg::FN_FIXLIT) ? 3'd0 : 3'd4;
                key_r <= (in_beat.func == cht_pkg::FN_FIXLIT) ? cht_pkg::RUN_KEY[0]
                                                               : cht_pkg::RUN_KEY[4];
                sym_r <= (in_beat.func == cht_pkg::FN_FIXLIT) ? cht_pkg::RUN_FIRST[0]
                                                               : cht_pkg::RUN_FIRST[4];
                state_r <= S_FIX;
              end
              cht_pkg::FN_LOOKUP: begin
                key_r   <= 16'({1'b0, in_beat.lookup_code} | (16'd1 << in_beat.lookup_length));
                look_r  <= 1'b1;
                state_r <= S_LOOK;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        // sweep after reset ends quietly, a requested clear ends with a beat
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MAP_DEPTH - 1'b1) begin
            state_r <= sweep_r ? S_IDLE : S_DONE;
            sweep_r <= 1'b0;
          end
        end
        S_FIX: begin
          key_r <= key_r + 1'b1;
          sym_r <= sym_r + 1'b1;
          if (sym_r == cht_pkg::RUN_LAST[run_r]) begin
            if (run_r == 3'd3 || run_r == 3'd4) begin
              state_r <= S_DONE;
            end else begin
              run_r <= run_r + 1'b1;
              key_r <= cht_pkg::RUN_KEY[run_r + 1'b1];
              sym_r <= cht_pkg::RUN_FIRST[run_r + 1'b1];
            end
          end
        end
        // histogram pass: read address cnt, count it next cycle
        S_HIST: begin
          if (KW'(cnt_r) >= KW'(count_r)) begin
            state_r <= S_NEXT;
            cnt_r   <= '0;
            code_r  <= '0;
            len_r   <= 4'd1;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_HIST_W;
          end
        end
        S_HIST_W: begin
          if (len_ok) hist_r[lrd_r] <= hist_r[lrd_r] + 1'b1;
          state_r <= S_HIST;
        end
        // next codes, one length per cycle
        S_NEXT: begin
          if (32'(len_r) <= MAX_CODE_LEN) begin
            next_r[len_r] <= 16'((code_r + 16'(len_r == 4'd1 ? 10'd0 : hist_r[len_r - 1'b1]))
                                 << 1);
            code_r <= 16'((code_r + 16'(len_r == 4'd1 ? 10'd0 : hist_r[len_r - 1'b1])) << 1);
          end else begin
            next_r[len_r] <= '0;
          end
          next_r[0] <= '0;
          len_r <= len_r + 1'b1;
          if (len_r == 4'd15) begin
            state_r <= S_WRITE;
            cnt_r   <= '0;
          end
        end
        S_WRITE: begin
          if (KW'(cnt_r) >= KW'(count_r)) begin
            count_r <= '0;
            state_r <= S_DONE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_WRITE_W;
          end
        end
        S_WRITE_W: begin
          if (len_ok) next_r[lrd_r] <= next_r[lrd_r] + 1'b1;
          state_r <= S_WRITE;
        end
        S_LOOK:   state_r <= S_LOOK_W;
        S_LOOK_W: state_r <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          out_beat.symbol   <= look_r ? $signed(mrd) : 10'sd0;
          out_beat.overflow <= ovf_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result beat only shows once the sequencer is back to idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");
  // result beat follows the done state
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid)
    else $error("missing result");
  // when overflow is reported, the stored symbol count is at most MAX_SYMBOLS
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.overflow) |-> (count_r <= CW'(MAX_SYMBOLS)))
    else $error("bad overflow");
`endif

endmodule
`default_nettype wire
